// ===== hw/rtl/hashed_block_buffer_cache_assert.svh =====
// Assertion macros shared by the cache checker.
// Clocked, reset-gated immediate-implication and next-cycle forms.
`ifndef HASHED_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define HASHED_BLOCK_BUFFER_CACHE_ASSERT_SVH

// Same-cycle implication
`define HBBC_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbbc assertion failed");

// Next-cycle implication
`define HBBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbbc assertion failed");

`endif

// ===== hw/rtl/hbbc_pkg.sv =====
// Shared types, codes and widths for the hashed block buffer cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbbc_pkg;

    localparam int HBBC_NUM_BUCKETS = 13;
    localparam int HBBC_NUM_WAYS    = 5;

    localparam int OP_W      = 2;
    localparam int DEV_W     = 8;
    localparam int BLK_W     = 24;
    localparam int WAYF_W    = 3;
    localparam int STAMP_W   = 32;
    localparam int COUNT_W   = 8;
    localparam int STATUS_W  = 3;

    // Digit width and step count of the bucket remainder unit
    localparam int MOD_DIG_W = 4;
    localparam int MOD_STEPS = BLK_W / MOD_DIG_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_PIN     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOFREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFDONE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT     = 3'd4;

    typedef struct packed {
        logic [DEV_W-1:0]   dev;
        logic [BLK_W-1:0]   blk;
        logic [COUNT_W-1:0] refc;
        logic [STAMP_W-1:0] last;
        logic               vld;
    } t_entry;

endpackage

`default_nettype wire

// ===== hw/rtl/hashed_block_buffer_cache.sv =====
// Hashed block buffer cache: bucketed tag table, oldest-use replacement.
// Get: the 6-step bucket remainder, then the way scan over the single RAM read port and a table update.
// Pin/release: the same remainder, then a read and an update of the given way.
// Bad opcode or way: straight to the response. Input stalls until each request is answered.
// After reset a clearing pass zeroes all NUM_BUCKETS*NUM_WAYS entries; input stalls.
`timescale 1ns / 1ps
`default_nettype none

module hashed_block_buffer_cache #(
    parameter int NUM_BUCKETS = hbbc_pkg::HBBC_NUM_BUCKETS,
    parameter int NUM_WAYS    = hbbc_pkg::HBBC_NUM_WAYS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hbbc_pkg::OP_W-1:0]     i_opcode,
    input  logic [hbbc_pkg::DEV_W-1:0]    i_device_id,
    input  logic [hbbc_pkg::BLK_W-1:0]    i_block_number,
    input  logic [hbbc_pkg::WAYF_W-1:0]   i_entry_way,
    input  logic [hbbc_pkg::STAMP_W-1:0]  i_now,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hbbc_pkg::STATUS_W-1:0] o_status,
    output logic [hbbc_pkg::WAYF_W-1:0]   o_way,
    output logic                          o_need_read
);

    import hbbc_pkg::*;

    localparam int NUM_ENTRIES = NUM_BUCKETS * NUM_WAYS;
    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int TW = RW + MOD_DIG_W;
    localparam int EW = $bits(t_entry);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_BASE,
        S_SCAN,
        S_GET_UPD,
        S_REF_RD,
        S_REF_UPD,
        S_RESP
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic [STEP_W-1:0]   r_cnt;
    logic [OP_W-1:0]     r_op;
    logic [DEV_W-1:0]    r_dev;
    logic [BLK_W-1:0]    r_blk;
    logic [BLK_W-1:0]    r_sh;
    logic [WAYF_W-1:0]   r_eway;
    logic [STAMP_W-1:0]  r_now;
    logic [RW-1:0]       r_rem;
    logic [AW-1:0]       r_base;
    logic [WW:0]         r_issue;
    logic                r_pend;
    logic [WW-1:0]       r_pend_way;
    logic                r_found;
    logic [WW-1:0]       r_sel;
    t_entry              r_hit_rec;
    logic                r_cand;
    logic [WW-1:0]       r_cand_way;
    logic [STAMP_W-1:0]  r_oldest;
    logic [STATUS_W-1:0] r_status;
    logic [WAYF_W-1:0]   r_way;
    logic                r_need;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [WAYF_W-1:0]   r_out_way;
    logic                r_out_need;

    logic [TW-1:0]       mod_t;
    logic [TW-1:0]       mod_sub;
    logic [RW-1:0]       n_rem;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;
    t_entry              rd_ent;
    logic [WW-1:0]       eway_ix;
    logic [STATUS_W-1:0] upd_status;
    logic [WAYF_W-1:0]   upd_way;
    logic                upd_need;
    logic                in_accept;
    logic                ent_match;
    logic                ent_older;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign rd_ent    = t_entry'(ram_rdata);
    assign eway_ix   = WW'(r_eway);
    assign ent_match = (rd_ent.dev == r_dev) && (rd_ent.blk == r_blk);
    assign ent_older = (rd_ent.refc == '0) && (!r_cand || (rd_ent.last < r_oldest));

    // Remainder digit step: shift in one digit, subtract the largest fitting multiple
    always_comb begin
        mod_t   = {r_rem, r_sh[BLK_W-1 -: MOD_DIG_W]};
        mod_sub = '0;
        for (int k = 1; k < (1 << MOD_DIG_W); k++) begin
            if (int'(mod_t) >= k * NUM_BUCKETS) begin
                mod_sub = TW'(k * NUM_BUCKETS);
            end
        end
        n_rem = RW'(mod_t - mod_sub);
    end

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_clr;
        ram_wdata  = '0;
        ram_raddr  = r_base + AW'(r_issue[WW-1:0]);
        upd_status = ST_NOFREE;
        upd_way    = '0;
        upd_need   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_GET_UPD: begin
                if (r_found) begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_base + AW'(r_sel);
                    ram_wdata      = r_hit_rec;
                    ram_wdata.last = r_now;
                    ram_wdata.vld  = 1'b1;
                    if (r_hit_rec.refc == COUNT_MAX) begin
                        upd_status = ST_SAT;
                    end else begin
                        ram_wdata.refc = r_hit_rec.refc + COUNT_W'(1);
                        upd_status     = ST_HIT;
                    end
                    upd_way  = WAYF_W'(r_sel);
                    upd_need = !r_hit_rec.vld;
                end else if (r_cand) begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_base + AW'(r_cand_way);
                    ram_wdata.dev  = r_dev;
                    ram_wdata.blk  = r_blk;
                    ram_wdata.refc = COUNT_W'(1);
                    ram_wdata.last = r_now;
                    ram_wdata.vld  = 1'b1;
                    upd_status     = ST_MISS;
                    upd_way        = WAYF_W'(r_cand_way);
                    upd_need       = 1'b1;
                end
            end
            S_REF_RD: begin
                ram_raddr = r_base + AW'(eway_ix);
            end
            S_REF_UPD: begin
                ram_we     = 1'b1;
                ram_waddr  = r_base + AW'(eway_ix);
                ram_wdata  = rd_ent;
                upd_status = ST_REFDONE;
                upd_way    = r_eway;
                if (r_op == OP_PIN) begin
                    if (rd_ent.refc == COUNT_MAX) begin
                        upd_status = ST_SAT;
                    end else begin
                        ram_wdata.refc = rd_ent.refc + COUNT_W'(1);
                    end
                end else begin
                    if (rd_ent.refc == '0) begin
                        upd_status = ST_SAT;
                    end else begin
                        ram_wdata.refc = rd_ent.refc - COUNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NUM_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_op    <= i_opcode;
                        r_dev   <= i_device_id;
                        r_blk   <= i_block_number;
                        r_sh    <= i_block_number;
                        r_eway  <= i_entry_way;
                        r_now   <= i_now;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_cand  <= 1'b0;
                        if ((i_opcode == OP_GET) ||
                            (((i_opcode == OP_PIN) || (i_opcode == OP_RELEASE)) &&
                             (int'(i_entry_way) < NUM_WAYS))) begin
                            r_state <= S_MOD;
                        end else begin
                            r_status <= ST_NOFREE;
                            r_way    <= '0;
                            r_need   <= 1'b0;
                            r_state  <= S_RESP;
                        end
                    end
                end
                S_MOD: begin
                    r_rem <= n_rem;
                    r_sh  <= r_sh << MOD_DIG_W;
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == STEP_W'(MOD_STEPS - 1)) begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_base  <= AW'(r_rem * NUM_WAYS);
                    r_state <= (r_op == OP_GET) ? S_SCAN : S_REF_RD;
                end
                S_SCAN: begin
                    if (int'(r_issue) < NUM_WAYS) begin
                        r_issue    <= r_issue + (WW+1)'(1);
                        r_pend     <= 1'b1;
                        r_pend_way <= r_issue[WW-1:0];
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (!r_found && ent_match) begin
                            r_found   <= 1'b1;
                            r_sel     <= r_pend_way;
                            r_hit_rec <= rd_ent;
                        end
                        if (ent_older) begin
                            r_cand     <= 1'b1;
                            r_cand_way <= r_pend_way;
                            r_oldest   <= rd_ent.last;
                        end
                        if (r_pend_way == WW'(NUM_WAYS - 1)) begin
                            r_state <= S_GET_UPD;
                        end
                    end
                end
                S_GET_UPD, S_REF_UPD: begin
                    r_status <= upd_status;
                    r_way    <= upd_way;
                    r_need   <= upd_need;
                    r_state  <= S_RESP;
                end
                S_REF_RD: begin
                    r_state <= S_REF_UPD;
                end
                S_RESP: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_way    <= r_way;
                        r_out_need   <= r_need;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    hbbc_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_way       = r_out_way;
    assign o_need_read = r_out_need;

endmodule

`default_nettype wire

// ===== hw/rtl/hbbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hbbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/hbbc_checker.sv =====
// Port-level checks for the hashed block buffer cache, bound to the top level.
// Depends on hbbc_pkg and hashed_block_buffer_cache_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "hashed_block_buffer_cache_assert.svh"

module hbbc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [hbbc_pkg::STATUS_W-1:0] i_status,
    input  logic [hbbc_pkg::WAYF_W-1:0]   i_way,
    input  logic                          i_need_read
);

    import hbbc_pkg::*;

    `HBBC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `HBBC_ASSERT_NXT(a_busy_after_item, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    `HBBC_ASSERT(a_nofree_shape, i_clk, i_rst_n, i_out_valid && (i_status == ST_NOFREE), (i_way == '0) && !i_need_read)
    `HBBC_ASSERT(a_need_read_get, i_clk, i_rst_n, i_out_valid && i_need_read, (i_status == ST_HIT) || (i_status == ST_MISS) || (i_status == ST_SAT))

endmodule

bind hashed_block_buffer_cache hbbc_checker u_hbbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_status    (o_status),
    .i_way       (o_way),
    .i_need_read (o_need_read)
);

`default_nettype wire
